@@ rtl/tcsf_pkg.sv @@
// Shared types and constants of the text cat stream filter.
// Used by the front, back and top level; depends on nothing.
package tcsf_pkg;

  localparam int unsigned MAX_RESULTS = 9;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [2:0] REG_NUMBER_ALL       = 3'd0;
  localparam logic [2:0] REG_NUMBER_NONBLANK  = 3'd1;
  localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd2;
  localparam logic [2:0] REG_SHOW_ENDS        = 3'd3;
  localparam logic [2:0] REG_SHOW_TABS        = 3'd4;
  localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd5;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_QUEST  = 8'd63;
  localparam logic [7:0] CH_UPPER_I = 8'd73;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CARET_OFFSET = 8'd64;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  typedef struct packed {
    logic             has_num;
    logic [7:0]       body0;
    logic [7:0]       body1;
    logic [CNT_W-1:0] last_idx;
  } entry_t;

endpackage

@@ rtl/tcsf_queue.sv @@
// Small request queue between the front and the back.
// Generic register FIFO; no package dependencies.
module tcsf_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output logic [WIDTH-1:0] rdata
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

@@ rtl/tcsf_front.sv @@
// Front end: accepts input bytes, tracks line state and the BCD line counter,
// and builds one output request per unsqueezed byte. Depends on tcsf_pkg.
module tcsf_front #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tcsf_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  input  logic [7:0]                      in_byte,
  output logic                            in_stall,
  input  logic                            full,
  output logic                            push,
  output tcsf_pkg::entry_t                entry,
  output logic [NUMBER_DIGITS-1:0][7:0]   num_chars
);
  import tcsf_pkg::*;

  localparam int unsigned SUM_W = CNT_W + 1;

  logic [1:0]                    newline_run;
  logic [1:0]                    newline_run_next;
  logic                          prev_nl;
  logic                          at_stream_start;
  logic [NUMBER_DIGITS-1:0][3:0] line_count_bcd;
  logic [NUMBER_DIGITS-1:0][3:0] line_count_bcd_next;

  logic       accept;
  logic       is_nl;
  logic       line_start;
  logic       drop;
  logic       num;
  logic [1:0] prior;
  logic       two;
  logic [SUM_W-1:0] total;

  assign accept     = in_valid && !full;
  assign in_stall   = full;
  assign is_nl      = (in_byte == CH_NL);
  assign line_start = at_stream_start || prev_nl;
  assign prior      = at_stream_start ? 2'd1 : newline_run;

  always_comb begin
    if (is_nl) begin
      newline_run_next = (prior == 2'd3) ? 2'd3 : prior + 2'd1;
    end else begin
      newline_run_next = 2'd0;
    end
  end

  assign drop = cfg.squeeze_blank && is_nl && (newline_run_next == 2'd3);
  assign num  = line_start &&
                (cfg.number_nonblank ? !is_nl : cfg.number_all);
  assign push = accept && !drop;

  always_comb begin
    entry.body0 = in_byte;
    entry.body1 = in_byte;
    two         = 1'b0;
    if (is_nl) begin
      if (cfg.show_ends) begin
        entry.body0 = CH_DOLLAR;
        two         = 1'b1;
      end
    end else if (in_byte == CH_TAB && cfg.show_tabs) begin
      entry.body0 = CH_CARET;
      entry.body1 = CH_UPPER_I;
      two         = 1'b1;
    end else if (cfg.show_nonprinting && in_byte < CH_SPACE && in_byte != CH_TAB) begin
      entry.body0 = CH_CARET;
      entry.body1 = in_byte + CARET_OFFSET;
      two         = 1'b1;
    end else if (cfg.show_nonprinting && in_byte == CH_DEL) begin
      entry.body0 = CH_CARET;
      entry.body1 = CH_QUEST;
      two         = 1'b1;
    end
    entry.has_num = num;
    total = (num ? SUM_W'(NUMBER_DIGITS + 1) : SUM_W'(0)) + (two ? SUM_W'(2) : SUM_W'(1));
    if (total > SUM_W'(MAX_RESULTS)) begin
      entry.last_idx = CNT_W'(MAX_RESULTS - 1);
    end else begin
      entry.last_idx = CNT_W'(total - SUM_W'(1));
    end
  end

  always_comb begin
    logic       nz;
    logic [3:0] d;
    nz = 1'b0;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      d = (line_count_bcd[i] > 4'd9) ? 4'd9 : line_count_bcd[i];
      nz = nz || (d != 4'd0) || (i == 0);
      num_chars[NUMBER_DIGITS - 1 - i] = nz ? (CH_ZERO + {4'd0, d}) : CH_SPACE;
    end
  end

  always_comb begin
    logic carry;
    logic all9;
    carry = 1'b1;
    all9  = 1'b1;
    line_count_bcd_next = line_count_bcd;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      all9 = all9 && (line_count_bcd[i] == 4'd9);
      if (carry) begin
        if (line_count_bcd[i] == 4'd9) begin
          line_count_bcd_next[i] = 4'd0;
        end else begin
          line_count_bcd_next[i] = line_count_bcd[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (all9) begin
      line_count_bcd_next = line_count_bcd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newline_run     <= 2'd0;
      prev_nl         <= 1'b0;
      at_stream_start <= 1'b1;
      line_count_bcd  <= {{(4 * NUMBER_DIGITS - 1){1'b0}}, 1'b1};
    end else if (accept) begin
      newline_run     <= newline_run_next;
      prev_nl         <= is_nl;
      at_stream_start <= 1'b0;
      if (num && !drop) begin
        line_count_bcd <= line_count_bcd_next;
      end
    end
  end

endmodule

@@ rtl/tcsf_back.sv @@
// Back end: walks the head request one output byte per cycle, while the output
// does not stall, into a registered output stage. Depends on tcsf_pkg.
module tcsf_back #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  tcsf_pkg::entry_t              head,
  input  logic [NUMBER_DIGITS-1:0][7:0] head_chars,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          last_of_run
);
  import tcsf_pkg::*;

  localparam int unsigned KW = (CNT_W > $clog2(NUMBER_DIGITS + 2)) ?
                               CNT_W : $clog2(NUMBER_DIGITS + 2);
  localparam int unsigned DW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

  logic [CNT_W-1:0] k;
  logic             advance;
  logic             is_last;
  logic [7:0]       sel_byte;
  logic [KW-1:0]    kx;
  logic [KW-1:0]    body_pos;

  assign advance = !out_valid || !out_stall;
  assign is_last = (k == head.last_idx);
  assign pop     = advance && head_valid && is_last;
  assign kx      = KW'(k);

  always_comb begin
    body_pos = head.has_num ? (kx - KW'(NUMBER_DIGITS + 1)) : kx;
    if (head.has_num && kx < KW'(NUMBER_DIGITS)) begin
      sel_byte = head_chars[DW'(kx)];
    end else if (head.has_num && kx == KW'(NUMBER_DIGITS)) begin
      sel_byte = CH_TAB;
    end else if (body_pos == '0) begin
      sel_byte = head.body0;
    end else begin
      sel_byte = head.body1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= head_valid;
      if (head_valid) begin
        k <= is_last ? '0 : k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      out_byte    <= sel_byte;
      last_of_run <= is_last;
    end
  end

endmodule

@@ rtl/text_cat_stream_filter.sv @@
// Top level of the text cat stream filter: register port, front, queue, back.
// Depends on tcsf_pkg, tcsf_front, tcsf_queue and tcsf_back.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_byte
//   out      output     out_valid / out_stall out_byte, last_of_run
//   cfg      input      APB psel/penable      paddr, pwdata, prdata
//
// One input byte is taken per cycle while the four-entry request queue has room.
// The back emits one output byte per cycle while out_stall is low; one input
// byte expands into at most nine output bytes, so the output stage throughput
// sets the sustained rate. Reset is synchronous and needs no sweep.
// A stall on the output fills the queue, then raises in_stall.
module text_cat_stream_filter #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run
);
  import tcsf_pkg::*;

  localparam int unsigned QW = $bits(entry_t) + 8 * NUMBER_DIGITS;

  cfg_t   cfg;
  logic   full;
  logic   push;
  logic   pop;
  logic   head_valid;
  entry_t entry;
  entry_t head;
  logic [NUMBER_DIGITS-1:0][7:0] num_chars;
  logic [NUMBER_DIGITS-1:0][7:0] head_chars;
  logic [QW-1:0] qdata;
  logic [2:0]    reg_idx;
  logic          cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_NUMBER_ALL:       cfg.number_all       <= pwdata[0];
        REG_NUMBER_NONBLANK:  cfg.number_nonblank  <= pwdata[0];
        REG_SQUEEZE_BLANK:    cfg.squeeze_blank    <= pwdata[0];
        REG_SHOW_ENDS:        cfg.show_ends        <= pwdata[0];
        REG_SHOW_TABS:        cfg.show_tabs        <= pwdata[0];
        REG_SHOW_NONPRINTING: cfg.show_nonprinting <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_NUMBER_ALL:       prdata[0] = cfg.number_all;
      REG_NUMBER_NONBLANK:  prdata[0] = cfg.number_nonblank;
      REG_SQUEEZE_BLANK:    prdata[0] = cfg.squeeze_blank;
      REG_SHOW_ENDS:        prdata[0] = cfg.show_ends;
      REG_SHOW_TABS:        prdata[0] = cfg.show_tabs;
      REG_SHOW_NONPRINTING: prdata[0] = cfg.show_nonprinting;
      default:              prdata[0] = 1'b0;
    endcase
  end

  tcsf_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .in_stall  (in_stall),
    .full      (full),
    .push      (push),
    .entry     (entry),
    .num_chars (num_chars)
  );

  tcsf_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    ({entry, num_chars}),
    .full     (full),
    .pop      (pop),
    .nonempty (head_valid),
    .rdata    (qdata)
  );

  assign head       = qdata[QW-1 -: $bits(entry_t)];
  assign head_chars = qdata[8*NUMBER_DIGITS-1:0];

  tcsf_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .head_chars  (head_chars),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for text_cat_stream_filter: directed and random byte streams
// checked byte by byte against a local formatting predictor; depends on tcsf_pkg.
module tb_top;
  import tcsf_pkg::*;

  localparam int ND          = 6;
  localparam int DRAIN_TAIL  = 48;
  localparam int LONG_HOLD   = 300;
  localparam int IDLE_LIMIT  = 4000;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } out_char_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [4:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;

  // formatter state as seen by the predictor
  cfg_t            opt_cfg    = '0;
  logic [1:0]      nl_run     = 2'd0;
  logic [7:0]      prev_byte  = CH_ZERO;
  logic            at_start   = 1'b1;
  logic [4*ND-1:0] line_bcd   = {{(4 * ND - 1){1'b0}}, 1'b1};

  out_char_t formatted_q[$];

  int  err_count     = 0;
  int  bytes_sent    = 0;
  int  bytes_checked = 0;
  int  settings_used = 0;
  int  idle_cycles   = 0;
  bit  quiet         = 1'b0;
  bit  hold_req      = 1'b0;
  int  rx_hold_left  = 0;
  int  rx_stall_left = 0;

  text_cat_stream_filter #(.NUMBER_DIGITS(ND)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] text_byte();
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 40)      b = 8'($urandom_range(CH_SPACE, CH_DEL - 1));
    else if (r < 55) b = CH_TAB;
    else if (r < 70) b = 8'($urandom_range(0, CH_SPACE - 1));
    else if (r < 77) b = CH_DEL;
    else if (r < 90) b = 8'($urandom_range(128, 255));
    else             b = 8'($urandom_range(0, 255));
    if (b == CH_NL) b = CH_SPACE;
    return b;
  endfunction

  // expected output bytes of one accepted input byte
  function automatic void format_byte(input logic [7:0] b);
    logic       line_start;
    logic       squeezed;
    logic       lead;
    logic       carry;
    logic [1:0] prior;
    logic [3:0] d;
    logic [4*ND-1:0] nines;
    logic [7:0] bytes_q[$];
    out_char_t  oc;

    line_start = at_start || (prev_byte == CH_NL);
    squeezed = 1'b0;
    if (b == CH_NL) begin
      prior = at_start ? 2'd1 : nl_run;
      nl_run = (prior < 2'd3) ? prior + 2'd1 : 2'd3;
      squeezed = opt_cfg.squeeze_blank && (nl_run == 2'd3);
    end else begin
      nl_run = 2'd0;
    end

    if (!squeezed) begin
      if (line_start && (opt_cfg.number_nonblank ? (b != CH_NL) : opt_cfg.number_all)) begin
        lead = 1'b1;
        for (int i = ND - 1; i >= 0; i--) begin
          d = line_bcd[4*i +: 4];
          if (d > 4'd9) d = 4'd9;
          if (d != 4'd0 || i == 0) lead = 1'b0;
          bytes_q.push_back(lead ? CH_SPACE : CH_ZERO + 8'(d));
        end
        bytes_q.push_back(CH_TAB);
        for (int i = 0; i < ND; i++) nines[4*i +: 4] = 4'd9;
        if (line_bcd != nines) begin
          carry = 1'b1;
          for (int i = 0; i < ND; i++) begin
            if (carry) begin
              if (line_bcd[4*i +: 4] < 4'd9) begin
                line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
                carry = 1'b0;
              end else begin
                line_bcd[4*i +: 4] = 4'd0;
              end
            end
          end
        end
      end
      if (b == CH_NL) begin
        if (opt_cfg.show_ends) bytes_q.push_back(CH_DOLLAR);
        bytes_q.push_back(b);
      end else if (b == CH_TAB && opt_cfg.show_tabs) begin
        bytes_q.push_back(CH_CARET);
        bytes_q.push_back(CH_UPPER_I);
      end else if (opt_cfg.show_nonprinting && b < CH_SPACE && b != CH_TAB) begin
        bytes_q.push_back(CH_CARET);
        bytes_q.push_back(b + CARET_OFFSET);
      end else if (opt_cfg.show_nonprinting && b == CH_DEL) begin
        bytes_q.push_back(CH_CARET);
        bytes_q.push_back(CH_QUEST);
      end else begin
        bytes_q.push_back(b);
      end
    end

    prev_byte = b;
    at_start = 1'b0;

    while (bytes_q.size() > MAX_RESULTS) void'(bytes_q.pop_back());
    foreach (bytes_q[i]) begin
      oc.value = bytes_q[i];
      oc.last = (i == bytes_q.size() - 1);
      formatted_q.push_back(oc);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    format_byte(b);
    bytes_sent++;
  endtask

  task automatic drain_output();
    in_valid <= 1'b0;
    while (formatted_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_option(input logic [2:0] idx, input logic value);
    logic [31:0] data;
    data = $urandom;
    data[0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_NUMBER_ALL:       opt_cfg.number_all = value;
      REG_NUMBER_NONBLANK:  opt_cfg.number_nonblank = value;
      REG_SQUEEZE_BLANK:    opt_cfg.squeeze_blank = value;
      REG_SHOW_ENDS:        opt_cfg.show_ends = value;
      REG_SHOW_TABS:        opt_cfg.show_tabs = value;
      REG_SHOW_NONPRINTING: opt_cfg.show_nonprinting = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_options(input cfg_t c);
    drain_output();
    write_option(REG_NUMBER_ALL, c.number_all);
    write_option(REG_NUMBER_NONBLANK, c.number_nonblank);
    write_option(REG_SQUEEZE_BLANK, c.squeeze_blank);
    write_option(REG_SHOW_ENDS, c.show_ends);
    write_option(REG_SHOW_TABS, c.show_tabs);
    write_option(REG_SHOW_NONPRINTING, c.show_nonprinting);
    settings_used++;
  endtask

  task automatic send_random_text(input int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(0, 6);
        repeat (len) begin
          send_byte(text_byte());
          n++;
        end
        len = $urandom_range(1, 4);
        repeat (len) begin
          send_byte(CH_NL);
          n++;
        end
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        n++;
      end
    end
  endtask

  task automatic test_stream_start();
    cfg_t c;
    c = '0;
    c.number_all = 1'b1;
    c.squeeze_blank = 1'b1;
    apply_options(c);
    send_byte(CH_NL);
    send_byte(CH_NL);
    send_byte(CH_NL);
    send_byte("a");
    send_byte(CH_NL);
    send_byte(CH_NL);
    send_byte(CH_NL);
  endtask

  task automatic test_plain_pass();
    apply_options('0);
    send_byte(8'd0);
    send_byte(CH_TAB);
    send_byte(CH_SPACE - 8'd1);
    send_byte(CH_DEL);
    send_byte(8'd128);
    send_byte(8'd255);
    send_byte("A");
    send_byte(CH_NL);
  endtask

  task automatic test_show_options();
    apply_options('1);
    send_byte(CH_NL);
    send_byte(CH_TAB);
    send_byte(8'd0);
    send_byte(CH_SPACE - 8'd1);
    send_byte(CH_DEL);
    send_byte(8'd255);
    send_byte(8'd128);
    send_byte("~");
    send_byte(CH_NL);
    send_byte(CH_NL);
  endtask

  task automatic test_spare_registers();
    drain_output();
    write_option(REG_SPARE_6, 1'b1);
    write_option(REG_SPARE_7, 1'b0);
    send_byte("x");
    send_byte(CH_TAB);
  endtask

  task automatic test_backpressure();
    cfg_t c;
    c = 6'($urandom_range(0, 63));
    c.number_all = 1'b1;
    apply_options(c);
    quiet = 1'b1;
    hold_req = 1'b1;
    send_random_text(30);
    quiet = 1'b0;
  endtask

  task automatic test_random_settings();
    cfg_t c;
    for (int p = 0; p < 7; p++) begin
      if (p == 0)      c = '0;
      else if (p == 1) c = '1;
      else             c = 6'($urandom_range(0, 63));
      quiet = (p == 3);
      apply_options(c);
      send_random_text(14);
      drain_output();
      send_random_text(14);
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    out_char_t want;
    int pick;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        bytes_checked++;
        if (formatted_q.size() == 0) begin
          err_count++;
          $error("unexpected output: out_byte %0d last_of_run %0d", out_byte, last_of_run);
        end else begin
          want = formatted_q.pop_front();
          if (out_byte !== want.value) begin
            err_count++;
            $error("out_byte: expected %0d, got %0d", want.value, out_byte);
          end
          if (last_of_run !== want.last) begin
            err_count++;
            $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
          end
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        rx_hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_stall <= 1'b1;
      end else begin
        pick = gap_len();
        rx_stall_left = (pick > 0) ? pick - 1 : 0;
        out_stall <= (pick > 0);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d bytes still due",
                 idle_cycles, formatted_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_stream_start();
    test_plain_pass();
    test_show_options();
    test_spare_registers();
    test_backpressure();
    test_random_settings();
    drain_output();
    $display("Sent %0d input bytes under %0d option settings, checked %0d output bytes.",
             bytes_sent, settings_used, bytes_checked);
    $display("Mismatches: %0d", err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tcsf_pkg.sv
rtl/tcsf_queue.sv
rtl/tcsf_front.sv
rtl/tcsf_back.sv
rtl/text_cat_stream_filter.sv
tb/tb_top.sv
